// File: sv/shfr_pkg.sv
`timescale 1ns / 1ps

package shfr_pkg;

  localparam int FuncW    = 2;
  localparam int ByteW    = 8;
  localparam int LenW     = 11;
  localparam int IndexW   = 10;
  localparam int TimeoutW = 24;
  localparam int SyncLen  = 4;

  localparam int MaxFrameDefault = 1024;

  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(83332);
  localparam logic [TimeoutW-1:0] ElapsedMax   = {TimeoutW{1'b1}};

  localparam logic [FuncW-1:0] FUNC_START = 2'd0;
  localparam logic [FuncW-1:0] FUNC_BYTE  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] byte_in;
    logic [LenW-1:0]  frame_length;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [IndexW-1:0] data_index;
    logic              data_valid;
    logic              frame_done;
    logic              timed_out;
    logic              spoken_to;
  } result_t;

  function automatic logic [ByteW-1:0] sync_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = 8'h48;
      2'd1:    b = 8'hFA;
      2'd2:    b = 8'hF3;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

// File: sv/sync_header_frame_receiver_top.sv
// a request is registered in the input stage, its result in the output stage on m_axis
// throughput: one request per cycle unless m_axis stalls; every item handled in one pass
// each item's match, count and compare work sits between the input and result registers
// reset: synchronous rst clears both stages, frame state and spoken-to flag
// reset: timeout register returns to 83332 ticks
`timescale 1ns / 1ps

module sync_header_frame_receiver_top
  import shfr_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // byte_in[7:0], frame_length[18:8], zero fill
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // data_byte[7:0], data_index[17:8],
                                              // timed_out[18], spoken_to[19],
                                              // zero fill
  output logic                m_axis_tuser,   // data_valid[0]
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TimeoutW-1:0] cfg_data
);

  in_item_t in_item, stage_item;
  result_t  core_result, out_result;
  logic     stage_valid, core_ready;

  assign in_item.func         = s_axis_tuser;
  assign in_item.byte_in      = s_axis_tdata[7:0];
  assign in_item.frame_length = s_axis_tdata[18:8];

  assign cfg_ready = 1'b1;

  shfr_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (stage_valid),
    .out_ready (core_ready),
    .out_item  (stage_item)
  );

  shfr_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (stage_valid && core_ready),
    .item      (stage_item),
    .result    (core_result)
  );

  shfr_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stage_valid),
    .in_ready   (core_ready),
    .in_result  (core_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata = {4'b0000, out_result.spoken_to, out_result.timed_out,
                         out_result.data_index, out_result.data_byte};
  assign m_axis_tuser = out_result.data_valid;
  assign m_axis_tlast = out_result.frame_done;

endmodule

// File: sv/shfr_in_stage.sv
`timescale 1ns / 1ps

module shfr_in_stage
  import shfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output in_item_t out_item
);

  logic     valid;
  in_item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: sv/shfr_core.sv
`timescale 1ns / 1ps

module shfr_core
  import shfr_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [TimeoutW-1:0] cfg_data,
  input  logic                step,
  input  in_item_t            item,
  output result_t             result
);

  logic [LenW-1:0]     position, position_next;
  logic [LenW-1:0]     target_length, target_length_next;
  logic [TimeoutW-1:0] elapsed, elapsed_next;
  logic                armed, armed_next;
  logic                spoken_flag, spoken_flag_next;
  logic [TimeoutW-1:0] timeout_ticks;

  logic [LenW-1:0] len_sat;
  logic            done;

  always_comb begin
    if (32'(item.frame_length) > 32'(MAX_FRAME)) begin
      len_sat = LenW'(MAX_FRAME);
    end else begin
      len_sat = item.frame_length;
    end
  end

  always_comb begin
    position_next      = position;
    target_length_next = target_length;
    elapsed_next       = elapsed;
    armed_next         = armed;
    spoken_flag_next   = spoken_flag;
    result             = '0;
    done               = 1'b0;

    case (item.func)
      FUNC_START: begin
        target_length_next = len_sat;
        position_next      = '0;
        elapsed_next       = '0;
        armed_next         = 1'b1;
        done               = (len_sat == '0);
      end
      FUNC_BYTE: begin
        if (armed) begin
          if (position < LenW'(SyncLen)) begin
            if (item.byte_in == sync_byte(position[1:0])) begin
              position_next = position + 1'b1;
            end else begin
              position_next = '0;
            end
          end else begin
            result.data_byte  = item.byte_in;
            result.data_index = position[IndexW-1:0];
            result.data_valid = 1'b1;
            position_next     = position + 1'b1;
          end
          done = (position_next >= target_length);
        end
      end
      FUNC_TICK: begin
        if (armed) begin
          if (elapsed != ElapsedMax) begin
            elapsed_next = elapsed + 1'b1;
          end
          if (spoken_flag && (elapsed_next > timeout_ticks)) begin
            armed_next       = 1'b0;
            result.timed_out = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      armed_next        = 1'b0;
      spoken_flag_next  = 1'b1;
      result.frame_done = 1'b1;
    end
    result.spoken_to = spoken_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      target_length <= '0;
      elapsed       <= '0;
      armed         <= 1'b0;
      spoken_flag   <= 1'b0;
    end else if (step) begin
      position      <= position_next;
      target_length <= target_length_next;
      elapsed       <= elapsed_next;
      armed         <= armed_next;
      spoken_flag   <= spoken_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
    end else if (cfg_write) begin
      timeout_ticks <= cfg_data;
    end
  end

endmodule

// File: sv/shfr_out_stage.sv
`timescale 1ns / 1ps

module shfr_out_stage
  import shfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_result,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid;
  result_t held;

  assign in_ready   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_result;
    end
  end

endmodule

// File: verif/frame_rx_monitor.sv
`timescale 1ns / 1ps

module frame_rx_monitor
  import shfr_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // byte_in[7:0], frame_length[18:8], zero fill
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[1:0]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [23:0]         m_axis_tdata,   // data_byte[7:0], data_index[17:8],
                                              // timed_out[18], spoken_to[19],
                                              // zero fill
  input  logic                m_axis_tuser,   // data_valid[0]
  input  logic                m_axis_tlast,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [TimeoutW-1:0] cfg_data,
  output int                  mismatch_count,
  output int                  results_taken,
  output int                  results_owed
);

  // header bytes, first one in the low byte
  localparam logic [31:0] HeaderWord = 32'h20F3FA48;

  logic [TimeoutW-1:0] rx_timeout;
  logic [LenW-1:0]     rx_pos;
  logic [LenW-1:0]     rx_target;
  logic [TimeoutW-1:0] rx_elapsed;
  logic                rx_armed;
  logic                rx_spoken;
  result_t             pending_results [$];
  int                  bad = 0;
  int                  taken = 0;

  function automatic result_t next_rx_result(input logic [FuncW-1:0] func,
                                             input logic [ByteW-1:0] rx_byte,
                                             input logic [LenW-1:0]  len);
    result_t r;
    r = '0;
    case (func)
      FUNC_START: begin
        rx_target  = (int'(len) > MAX_FRAME) ? LenW'(MAX_FRAME) : len;
        rx_pos     = '0;
        rx_elapsed = '0;
        rx_armed   = 1'b1;
      end
      FUNC_BYTE: if (rx_armed) begin
        if (rx_pos < SyncLen) begin
          rx_pos = (rx_byte == HeaderWord[8*rx_pos[1:0] +: 8]) ? rx_pos + 1'b1 : '0;
        end else begin
          r.data_byte  = rx_byte;
          r.data_index = rx_pos[IndexW-1:0];
          r.data_valid = 1'b1;
          rx_pos       = rx_pos + 1'b1;
        end
      end
      FUNC_TICK: if (rx_armed) begin
        if (rx_elapsed != ElapsedMax) rx_elapsed = rx_elapsed + 1'b1;
        if (rx_spoken && rx_elapsed > rx_timeout) begin
          rx_armed    = 1'b0;
          r.timed_out = 1'b1;
        end
      end
      default: ;
    endcase
    // frame complete on a start or an accepted byte
    if ((func == FUNC_START || func == FUNC_BYTE) && rx_armed && rx_pos >= rx_target) begin
      rx_armed     = 1'b0;
      rx_spoken    = 1'b1;
      r.frame_done = 1'b1;
    end
    r.spoken_to = rx_spoken;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      bad++;
      $display("%0t %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rx_timeout = TimeoutReset;
      rx_pos     = '0;
      rx_target  = '0;
      rx_elapsed = '0;
      rx_armed   = 1'b0;
      rx_spoken  = 1'b0;
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        taken++;
        if (pending_results.size() == 0) begin
          bad++;
          $display("%0t result expected none actual %h/%b/%b", $time, m_axis_tdata,
                   m_axis_tuser, m_axis_tlast);
        end else begin
          want = pending_results.pop_front();
          check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
          check_field("data_index", want.data_index, m_axis_tdata[17:8]);
          check_field("data_valid", want.data_valid, m_axis_tuser);
          check_field("frame_done", want.frame_done, m_axis_tlast);
          check_field("timed_out", want.timed_out, m_axis_tdata[18]);
          check_field("spoken_to", want.spoken_to, m_axis_tdata[19]);
        end
      end
      if (cfg_valid && cfg_ready) rx_timeout = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(next_rx_result(s_axis_tuser, s_axis_tdata[7:0],
                                                 s_axis_tdata[18:8]));
      end
    end
    mismatch_count <= bad;
    results_taken  <= taken;
    results_owed   <= pending_results.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import shfr_pkg::*;

  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;
  logic [FuncW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TimeoutW-1:0] cfg_data = '0;

  int mismatch_count;
  int results_taken;
  int results_owed;
  int requests_sent = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sync_header_frame_receiver_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  frame_rx_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .results_taken (results_taken),
    .results_owed  (results_owed)
  );

  // result side back-pressure
  always @(posedge clk) begin
    if (rst || steady) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(1, 18) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_request(input logic [FuncW-1:0] func, input logic [ByteW-1:0] rx_byte,
                              input logic [LenW-1:0] len);
    if (!steady && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, len, rx_byte};
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_taken != requests_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TimeoutW-1:0] ticks);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic stray_tick(inout int n);
    if ($urandom_range(0, 9) == 0) begin
      push_request(FUNC_TICK, ByteW'($urandom), LenW'($urandom));
      n++;
    end
  endtask

  task automatic frame_burst(input bit full, output int n);
    int len, eff, idx;
    n = 0;
    if (full || $urandom_range(0, 59) == 0) len = $urandom_range(MaxFrameDefault, 2047);
    else len = $urandom_range(0, 24);
    eff = (len > MaxFrameDefault) ? MaxFrameDefault : len;
    push_request(FUNC_START, ByteW'($urandom), LenW'(len));
    n++;
    idx = 0;
    while (idx < SyncLen && idx < eff) begin
      stray_tick(n);
      if ($urandom_range(0, 11) == 0) begin
        // broken header
        push_request(FUNC_BYTE, sync_byte(2'(idx)) ^ ByteW'($urandom_range(1, 255)),
                     LenW'($urandom));
        idx = 0;
      end else begin
        push_request(FUNC_BYTE, sync_byte(2'(idx)), LenW'($urandom));
        idx++;
      end
      n++;
    end
    while (idx < eff && (full || $urandom_range(0, 299) != 0)) begin
      stray_tick(n);
      push_request(FUNC_BYTE, ByteW'($urandom), LenW'($urandom));
      idx++;
      n++;
    end
  endtask

  task automatic random_phase(input int quota);
    int counted, n, k;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        frame_burst(1'b0, n);
        counted += n;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          k = $urandom_range(0, 3);
          push_request(FuncW'(k), ByteW'($urandom), LenW'($urandom));
          if (k == FUNC_START) counted++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ignored while idle
    push_request(FUNC_BYTE, 8'h48, '0);
    push_request(FUNC_TICK, 8'hFF, 11'h7FF);
    push_request(FUNC_UNUSED, 8'hFF, 11'h7FF);

    set_timeout('0);
    // no abort before the first frame completes
    push_request(FUNC_START, 8'h00, 11'd6);
    push_request(FUNC_TICK, 8'h00, '0);
    // failing header byte is not taken as a new 'H'
    push_request(FUNC_BYTE, 8'h48, '0);
    push_request(FUNC_BYTE, 8'h48, '0);
    push_request(FUNC_BYTE, 8'h48, '0);
    push_request(FUNC_BYTE, 8'hFA, '0);
    push_request(FUNC_BYTE, 8'hF3, '0);
    push_request(FUNC_BYTE, 8'h20, '0);
    push_request(FUNC_BYTE, 8'h00, '0);
    push_request(FUNC_BYTE, 8'hFF, '0);
    // zero and short length
    push_request(FUNC_START, 8'hFF, 11'd0);
    push_request(FUNC_START, 8'h00, 11'd2);
    push_request(FUNC_BYTE, 8'h48, '0);
    push_request(FUNC_BYTE, 8'hFA, '0);
    // oversized, then restart
    push_request(FUNC_START, 8'h00, 11'h7FF);
    push_request(FUNC_START, 8'h00, 11'd5);
    push_request(FUNC_BYTE, 8'h48, '0);
    push_request(FUNC_BYTE, 8'hFA, '0);
    push_request(FUNC_BYTE, 8'hF3, '0);
    push_request(FUNC_BYTE, 8'h20, '0);
    push_request(FUNC_BYTE, 8'hA5, '0);
    // timeout once spoken to
    push_request(FUNC_START, 8'h00, 11'd8);
    push_request(FUNC_TICK, 8'h00, '0);
    push_request(FUNC_BYTE, 8'h48, '0);

    set_timeout({TimeoutW{1'b1}});
    random_phase(80);
    set_timeout(TimeoutW'(3));
    random_phase(80);
    set_timeout(TimeoutW'($urandom));
    random_phase(80);
    set_timeout(TimeoutW'($urandom_range(1, 40)));
    random_phase(80);
    set_timeout('0);
    steady <= 1'b1;
    random_phase(80);
    settle();

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("[sync_header_frame_receiver_top] OK");
    end else begin
      $display("[sync_header_frame_receiver_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[sync_header_frame_receiver_top] ERROR");
    $finish;
  end

endmodule

// File: files.f
sv/shfr_pkg.sv
sv/shfr_in_stage.sv
sv/shfr_core.sv
sv/shfr_out_stage.sv
sv/sync_header_frame_receiver_top.sv
verif/frame_rx_monitor.sv
verif/tb.sv
